FILE: sv/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

  // register map (index = byte address / 4)
  localparam logic REG_URL_ALPHABET = 1'b0;

  // ASCII codes
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_PLUS    = 8'h2b;
  localparam logic [7:0] ASCII_SLASH   = 8'h2f;
  localparam logic [7:0] ASCII_MINUS   = 8'h2d;
  localparam logic [7:0] ASCII_UNDER   = 8'h5f;
  localparam logic [7:0] ASCII_EQUAL   = 8'h3d;
  localparam logic [7:0] ASCII_COMMA   = 8'h2c;

  typedef logic [5:0] sextet_t;

  // one queued job: up to four characters of one input item
  typedef struct packed {
    logic [3:0][5:0] sextet;   // character codes, slot 0 first
    logic [3:0]      pad;      // slot is a pad character
    logic [1:0]      last_idx; // last used slot
    logic            eom;      // last slot closes the message
  } job_t;

  function automatic logic [7:0] sextet_char(sextet_t v, logic url);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = ASCII_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = ASCII_LOWER_A + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = ASCII_ZERO + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = url ? ASCII_MINUS : ASCII_PLUS;
    end else begin
      c = url ? ASCII_UNDER : ASCII_SLASH;
    end
    return c;
  endfunction

  function automatic logic [7:0] pad_char(logic url);
    return url ? ASCII_COMMA : ASCII_EQUAL;
  endfunction

endpackage

`default_nettype wire

FILE: sv/b64e_in_if.sv
`default_nettype none

interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

`default_nettype wire

FILE: sv/b64e_out_if.sv
`default_nettype none

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       final_char;

  modport source (output valid, output out_char, output final_char, input ready);
  modport sink (input valid, input out_char, input final_char, output ready);
endinterface

`default_nettype wire

FILE: sv/b64e_front.sv
`default_nettype none

// Splits each byte into sextets, keeps the group phase and leftover bits.
module b64e_front (
  input  wire logic          clk,
  input  wire logic          rst,
  b64e_in_if.sink            in_ch,
  output b64e_pkg::job_t     job,
  output logic               job_valid,
  input  wire logic          job_ready
);
  import b64e_pkg::*;

  localparam logic [1:0] PH0 = 2'd0;
  localparam logic [1:0] PH1 = 2'd1;
  localparam logic [1:0] PH2 = 2'd2;

  logic [1:0] phase, phase_next;
  logic [3:0] carry, carry_next;
  logic       accept;
  logic [7:0] b;
  logic       eom;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid;
  assign accept      = in_ch.valid && job_ready;
  assign b           = in_ch.data_byte;
  assign eom         = in_ch.end_of_message;

  always_comb begin
    job        = '0;
    job.eom    = eom;
    phase_next = phase;
    carry_next = carry;
    unique case (phase)
      PH1: begin
        job.sextet[0] = {carry[1:0], b[7:4]};
        job.sextet[1] = {b[3:0], 2'b00};
        job.pad[2]    = 1'b1;
        job.last_idx  = eom ? 2'd2 : 2'd0;
        carry_next    = b[3:0];
        phase_next    = PH2;
      end
      PH2: begin
        job.sextet[0] = {carry, b[7:6]};
        job.sextet[1] = b[5:0];
        job.last_idx  = 2'd1;
        carry_next    = '0;
        phase_next    = PH0;
      end
      default: begin
        // phase 0; the unused code behaves the same
        job.sextet[0] = b[7:2];
        job.sextet[1] = {b[1:0], 4'b0000};
        job.pad[2]    = 1'b1;
        job.pad[3]    = 1'b1;
        job.last_idx  = eom ? 2'd3 : 2'd0;
        carry_next    = {2'b00, b[1:0]};
        phase_next    = PH1;
      end
    endcase
    if (eom) begin
      carry_next = '0;
      phase_next = PH0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH0;
      carry <= '0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

  a_eom_restarts_group: assert property (@(posedge clk) disable iff (rst)
    accept && eom |=> phase == PH0 && carry == 4'd0)
    else $error("group phase not cleared after end of message");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("group phase holds unused code");

endmodule

`default_nettype wire

FILE: sv/b64e_job_fifo.sv
`default_nettype none

// Short job queue between front and back; ready depends on fill only.
module b64e_job_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire b64e_pkg::job_t push_job,
  input  wire logic          push_valid,
  output logic               push_ready,
  output b64e_pkg::job_t     head,
  output logic               head_valid,
  input  wire logic          pop
);
  import b64e_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job popped from empty queue");

endmodule

`default_nettype wire

FILE: sv/b64e_back.sv
`default_nettype none

// Walks the head job into the output register, one character per cycle unless out_ch stalls.
module b64e_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           url,
  input  wire b64e_pkg::job_t head,
  input  wire logic           head_valid,
  output logic                pop,
  b64e_out_if.source          out_ch
);
  import b64e_pkg::*;

  logic [1:0] idx;
  logic       ovalid;
  logic [7:0] ochar;
  logic       ofinal;
  logic       load;
  logic       at_last;
  logic [7:0] cur_char;

  assign load     = !ovalid || out_ch.ready;
  assign at_last  = idx == head.last_idx;
  assign pop      = load && head_valid && at_last;
  assign cur_char = head.pad[idx] ? pad_char(url) : sextet_char(head.sextet[idx], url);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= head_valid;
      if (head_valid) begin
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      ochar  <= cur_char;
      ofinal <= head.eom && at_last;
    end
  end

  assign out_ch.valid      = ovalid;
  assign out_ch.out_char   = ochar;
  assign out_ch.final_char = ofinal;

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.last_idx)
    else $error("character index past end of job");

  a_idx_zero_idle: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> idx == 2'd0)
    else $error("character index left mid job with queue empty");

endmodule

`default_nettype wire

FILE: sv/base64_stream_encoder_unit.sv
`default_nettype none

// Channel   Dir  Payload                         Handshake
// in_ch     in   data_byte[7:0], end_of_message  valid/ready
// out_ch    out  out_char[7:0], final_char       valid/ready
// apb       in   url_alphabet at byte addr 0     psel/penable/pwrite, pready=1
//
// One character leaves per cycle from a single output register unless out_ch
// stalls; an item yields 1, 1, 2 characters mid-group, up to 4 at end.
// A byte is taken in the cycle after the previous one while the job queue
// (JOB_DEPTH entries) has room; in_ch.ready depends on queue fill only.
// Synchronous reset clears group phase, leftover bits, queue and output.
// An output stall fills the queue, then holds in_ch.ready low.
module base64_stream_encoder_unit #(
  parameter int JOB_DEPTH = 2   // job queue entries, 2 or more
) (
  input  wire logic        clk,
  input  wire logic        rst,
  b64e_in_if.sink          in_ch,
  b64e_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import b64e_pkg::*;

  logic url_alphabet;
  logic cfg_write;
  logic reg_sel;

  job_t front_job, head;
  logic front_valid, front_ready;
  logic head_valid, pop;

  // config port: single register, writes complete in the access phase
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet <= 1'b0;
    end else if (cfg_write && reg_sel == REG_URL_ALPHABET) begin
      url_alphabet <= pwdata[0];
    end
  end

  assign prdata = (reg_sel == REG_URL_ALPHABET) ? {31'b0, url_alphabet} : '0;

  // front: byte to sextet job
  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // decoupling queue
  b64e_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // back: one character per cycle unless out_ch stalls
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .url        (url_alphabet),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

FILE: sim/tb_base64_stream_encoder_unit.sv
`timescale 1ns / 1ps

module tb_base64_stream_encoder_unit;
  import b64e_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 80;

  // Character sets, char i in slot i
  localparam logic [0:63][7:0] STD_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [0:63][7:0] URL_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } b64_char_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_stream_encoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Encoder state as the block should hold it
  logic       cfg_url;
  logic [1:0] grp_phase;
  logic [3:0] grp_carry;
  b64_char_t  pending_chars[$];
  b64_char_t  want_c;

  int errors;
  int cycles;
  int n_bytes;
  int n_msgs;
  int n_chars;
  int n_cfg_writes;
  int n_in_stalls;

  // Sender and receiver knobs
  int tx_gap_max;
  int burst_left;
  bit tx_offering;
  int rx_stall_pct;
  int rx_hold_req;
  int rx_hold_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d chars still owed", $time, pending_chars.size());
      $display("tb_base64_stream_encoder_unit NOT OK");
      $finish;
    end
  end

  function automatic logic [7:0] symbol_of(input logic [5:0] s);
    return cfg_url ? URL_ALPHA[s] : STD_ALPHA[s];
  endfunction

  function automatic void push_char(input logic [7:0] c);
    pending_chars.push_back('{ch: c, fin: 1'b0});
  endfunction

  // Expected characters for one accepted byte; the sextet that straddles
  // two bytes is only produced once the second byte shows up or the message ends.
  function automatic void encode_item(input logic [7:0] b, input logic eom);
    logic [7:0] pad;
    pad = cfg_url ? ASCII_COMMA : ASCII_EQUAL;
    case (grp_phase)
      2'd1: begin
        push_char(symbol_of({grp_carry[1:0], b[7:4]}));
        grp_carry = b[3:0];
        grp_phase = 2'd2;
        if (eom) begin
          push_char(symbol_of({grp_carry, 2'b00}));
          push_char(pad);
        end
      end
      2'd2: begin
        push_char(symbol_of({grp_carry, b[7:6]}));
        push_char(symbol_of(b[5:0]));
        grp_carry = 4'd0;
        grp_phase = 2'd0;
      end
      default: begin
        push_char(symbol_of(b[7:2]));
        grp_carry = {2'b00, b[1:0]};
        grp_phase = 2'd1;
        if (eom) begin
          push_char(symbol_of({grp_carry[1:0], 4'd0}));
          push_char(pad);
          push_char(pad);
        end
      end
    endcase
    if (eom) begin
      pending_chars[pending_chars.size() - 1].fin = 1'b1;
      grp_phase = 2'd0;
      grp_carry = 4'd0;
    end
  endfunction

  // Output check first, then prediction for the byte taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        n_chars++;
        if (pending_chars.size() == 0) begin
          errors++;
          $display("%0t unexpected char: exp none, got %h final %b",
                   $time, out_ch.out_char, out_ch.final_char);
        end else begin
          want_c = pending_chars.pop_front();
          if (out_ch.out_char !== want_c.ch) begin
            errors++;
            $display("%0t out_char: exp %h, got %h", $time, want_c.ch, out_ch.out_char);
          end
          if (out_ch.final_char !== want_c.fin) begin
            errors++;
            $display("%0t final_char: exp %b, got %b",
                     $time, want_c.fin, out_ch.final_char);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        n_bytes++;
        if (in_ch.end_of_message) n_msgs++;
        encode_item(in_ch.data_byte, in_ch.end_of_message);
      end else if (in_ch.valid) begin
        n_in_stalls++;
      end
    end
  end

  // Receiver: random stall rate, plus long hold-offs on request
  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    if (burst_left == 0) begin
      if (tx_gap_max > 0) begin
        if (tx_offering) in_ch.valid <= 1'b0;
        tx_offering = 0;
        repeat ($urandom_range(tx_gap_max, 1)) @(posedge clk);
      end
      burst_left = $urandom_range(8, 1);
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.end_of_message <= eom;
    tx_offering = 1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every owed char is out
  task automatic drain();
    if (tx_offering) in_ch.valid <= 1'b0;
    tx_offering = 0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write_url(input logic url);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_URL_ALPHABET, 2'b00};
    pwdata  <= {31'd0, url};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_url = url;
    n_cfg_writes++;
  endtask

  task automatic apb_check_url();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_URL_ALPHABET, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'd0, cfg_url}) begin
      errors++;
      $display("%0t url_alphabet readback: exp %h, got %h",
               $time, {31'd0, cfg_url}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Every group phase closing a message, all-zero and all-one bytes, and
  // the two alphabet-specific symbols, under both alphabets.
  task automatic test_directed();
    tx_gap_max = 0;
    rx_stall_pct = 0;
    apb_check_url();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hfb, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hfb, 1'b1);
    drain();
    apb_write_url(1'b1);
    apb_check_url();
    send_byte(8'hfb, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'hbe, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();
    apb_write_url(1'b0);
  endtask

  // Alphabet flipped while a message is half done: the straddling sextet
  // must come out in the alphabet in force when its second byte arrives.
  task automatic test_alphabet_switch();
    tx_gap_max = 2;
    rx_stall_pct = 20;
    send_byte(8'hff, 1'b0);
    drain();
    apb_write_url(1'b1);
    send_byte(8'hf0, 1'b0);
    drain();
    apb_write_url(1'b0);
    send_byte(8'h3f, 1'b0);
    send_byte(8'hfc, 1'b0);
    drain();
    apb_write_url(1'b1);
    send_byte(8'hfe, 1'b1);
    drain();
  endtask

  // Receiver holds off long enough that the job queue fills and the
  // block has to refuse bytes; sender keeps pushing one long message.
  task automatic test_backpressure();
    int i;
    tx_gap_max = 0;
    rx_stall_pct = 0;
    rx_hold_req = 120;
    for (i = 0; i < 24; i++) send_byte(8'($urandom_range(255)), i == 23);
    drain();
  endtask

  task automatic test_random();
    int sent;
    int len;
    int i;
    logic [7:0] b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(2) == 0) begin
        drain();
        apb_write_url(1'($urandom_range(1)));
      end
      case ($urandom_range(3))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 30;
        2: rx_stall_pct = 70;
        default: rx_stall_pct = 90;
      endcase
      tx_gap_max = ($urandom_range(2) == 0) ? 0 : 4;
      len = ($urandom_range(7) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      for (i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0: b = 8'h00;
          1: b = 8'hff;
          default: b = 8'($urandom_range(255));
        endcase
        send_byte(b, i == len - 1);
        sent++;
        // occasional alphabet flip between two bytes of one message
        if (i != len - 1 && $urandom_range(11) == 0) begin
          drain();
          apb_write_url(~cfg_url);
        end
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    cfg_url = 1'b0;
    grp_phase = 2'd0;
    grp_carry = 4'd0;
    errors = 0;
    cycles = 0;
    n_bytes = 0;
    n_msgs = 0;
    n_chars = 0;
    n_cfg_writes = 0;
    n_in_stalls = 0;
    tx_gap_max = 0;
    burst_left = 0;
    tx_offering = 0;
    rx_stall_pct = 0;
    rx_hold_req = 0;
    rx_hold_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_alphabet_switch();
    test_backpressure();
    test_random();

    drain();
    repeat (10) @(posedge clk);
    $display("Encoded %0d bytes in %0d messages, %0d chars compared, %0d alphabet writes.",
             n_bytes, n_msgs, n_chars, n_cfg_writes);
    $display("Input refused for %0d cycles under output backpressure.", n_in_stalls);
    if (errors == 0) begin
      $display("tb_base64_stream_encoder_unit OK");
    end else begin
      $display("tb_base64_stream_encoder_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/b64e_pkg.sv
sv/b64e_in_if.sv
sv/b64e_out_if.sv
sv/b64e_front.sv
sv/b64e_job_fifo.sv
sv/b64e_back.sv
sv/base64_stream_encoder_unit.sv
sim/tb_base64_stream_encoder_unit.sv
